/* hdl/okr_pkg.sv */
// okr_pkg: shared types and constants of the opposing key resolver
// used by okr_ctrl, okr_datapath and opposing_key_resolver; no dependencies
package okr_pkg;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_EVAL    = 2'd2,
        OP_LOAD    = 2'd3
    } t_op;

    localparam int MODE_W   = 3;
    localparam int POINT_W  = 15;
    localparam int TRAVEL_W = 16;

    localparam logic [MODE_W-1:0] MODE_LAST_WINS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOW_PRIO  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH_PRIO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEUTRAL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MOST_PRESSED = 3'd4;

    localparam int unsigned UM_PER_TENTH = 100;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic emit2;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] num_results;
    } t_dp_status;

endpackage

/* hdl/okr_ctrl.sv */
// okr_ctrl: sequencing state machine of the opposing key resolver
// depends on okr_pkg for the command and status structs
module okr_ctrl import okr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       o_busy,
    output logic       o_strobe,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT2
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;
    logic   w_accept;

    assign w_accept = start && !r_busy;

    assign o_cmd.accept = w_accept;
    assign o_cmd.exec   = (r_state == ST_READ);
    assign o_cmd.emit2  = (r_state == ST_EMIT2);

    always_comb begin
        n_state = ST_IDLE;
        case (r_state)
            ST_IDLE, ST_EMIT2: begin
                n_state = w_accept ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                n_state = (i_status.num_results == 2'd2) ? ST_EMIT2 : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy   = (n_state == ST_READ);
        n_strobe = ((r_state == ST_READ) && (i_status.num_results != 2'd0))
                   || (r_state == ST_EMIT2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state != ST_READ))
        else $error("table read phase lasted more than one cycle");

    a_second_follows_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT2) |-> $past(r_state == ST_READ))
        else $error("second command not directly after the first");

    a_busy_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state == ST_READ))
        else $error("busy out of step with the table read phase");

endmodule

/* hdl/okr_datapath.sv */
// okr_datapath: key settings memory, enable and override flags, pair resolution
// and command registers; depends on okr_pkg
module okr_datapath import okr_pkg::*; #(
    parameter int KEY_COUNT            = 64,
    parameter int DEFAULT_POINT_TENTHS = 35
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic [1:0]                 i_op,
    input  logic [5:0]                 i_key,
    input  logic                       i_key_is_down,
    input  logic                       i_partner_is_down,
    input  logic signed [TRAVEL_W-1:0] i_key_travel,
    input  logic signed [TRAVEL_W-1:0] i_partner_travel,
    input  logic [7:0]                 i_new_partner,
    input  logic [MODE_W-1:0]          i_new_mode,
    input  logic                       i_new_full_enable,
    input  logic [7:0]                 i_new_point_tenths,
    output logic [5:0]                 o_target_key,
    output logic                       o_make_pressed,
    output logic                       o_last
);

    localparam int PW = $clog2(KEY_COUNT);
    localparam int SD = (KEY_COUNT < 64) ? KEY_COUNT : 64;
    localparam int KW = $clog2(SD);
    localparam int EW = PW + MODE_W + 1 + POINT_W;
    localparam logic [POINT_W-1:0] DEFAULT_POINT =
        POINT_W'(DEFAULT_POINT_TENTHS * UM_PER_TENTH);

    // captured event
    t_op                        r_op;
    logic [5:0]                 r_key;
    logic                       r_kdown;
    logic                       r_pdown;
    logic signed [TRAVEL_W-1:0] r_ktr;
    logic signed [TRAVEL_W-1:0] r_ptr;
    logic [7:0]                 r_np;
    logic [MODE_W-1:0]          r_nm;
    logic                       r_nf;
    logic [7:0]                 r_npt;

    // settings memory: partner, mode, exception flag, point in micrometres
    logic [EW-1:0]        r_settings [SD];
    logic [EW-1:0]        r_rd;
    logic [SD-1:0]        r_enabled;
    logic [KEY_COUNT-1:0] r_override;

    // command registers
    logic [5:0]    r_out_key;
    logic          r_out_press;
    logic          r_out_last;
    logic [PW-1:0] r_c1_key;
    logic          r_c1_press;

    logic [PW-1:0]              w_key_p;
    logic [KW-1:0]              w_key_s;
    logic [PW-1:0]              w_partner;
    logic [MODE_W-1:0]          w_mode;
    logic                       w_full;
    logic [POINT_W-1:0]         w_point;
    logic signed [TRAVEL_W-1:0] w_point_s;
    logic                       w_in_range;
    logic                       w_enabled;
    logic                       w_key_lt;
    logic                       w_load_ok;
    logic [POINT_W-1:0]         w_new_point;
    logic                       w_rel_key;
    logic                       w_rel_partner;
    logic [1:0]                 w_n;
    logic [PW-1:0]              w_c0_key;
    logic                       w_c0_press;
    logic [PW-1:0]              w_c1_key;
    logic                       w_c1_press;

    assign w_key_p     = PW'(r_key);
    assign w_key_s     = KW'(r_key);
    assign w_partner   = r_rd[EW-1 -: PW];
    assign w_mode      = r_rd[POINT_W+1 +: MODE_W];
    assign w_full      = r_rd[POINT_W];
    assign w_point     = r_rd[POINT_W-1:0];
    assign w_point_s   = $signed({1'b0, w_point});
    assign w_in_range  = (9'(r_key) < 9'(KEY_COUNT));
    assign w_enabled   = w_in_range && r_enabled[w_key_s];
    assign w_key_lt    = (9'(r_key) < 9'(w_partner));
    assign w_load_ok   = (9'(r_np) < 9'(KEY_COUNT)) && (r_np != 8'(r_key));
    assign w_new_point = POINT_W'(r_npt) * POINT_W'(UM_PER_TENTH);
    assign w_rel_key     = r_kdown && r_override[w_key_p];
    assign w_rel_partner = r_pdown && r_override[w_partner];

    always_comb begin
        w_n        = 2'd0;
        w_c0_key   = w_partner;
        w_c0_press = 1'b0;
        w_c1_key   = w_partner;
        w_c1_press = 1'b0;
        if (w_enabled) begin
            case (r_op)
                OP_PRESS: begin
                    case (w_mode)
                        MODE_LAST_WINS: begin
                            w_n = 2'd1;
                        end
                        MODE_LOW_PRIO: begin
                            w_n      = 2'd1;
                            w_c0_key = w_key_lt ? w_partner : w_key_p;
                        end
                        MODE_HIGH_PRIO: begin
                            w_n      = 2'd1;
                            w_c0_key = w_key_lt ? w_key_p : w_partner;
                        end
                        MODE_NEUTRAL: begin
                            w_n      = 2'd2;
                            w_c0_key = w_key_p;
                        end
                        default: begin
                            w_n = 2'd0;
                        end
                    endcase
                end
                OP_RELEASE: begin
                    if (w_mode <= MODE_NEUTRAL) begin
                        w_c0_press = 1'b1;
                        w_c1_press = 1'b1;
                        if (w_rel_key) begin
                            w_c0_key = w_key_p;
                            w_n      = w_rel_partner ? 2'd2 : 2'd1;
                        end else if (w_rel_partner) begin
                            w_n = 2'd1;
                        end
                    end
                end
                OP_EVAL: begin
                    if ((w_mode == MODE_MOST_PRESSED) && w_key_lt && r_kdown && r_pdown) begin
                        w_n = 2'd2;
                        if (w_full && (r_ktr >= w_point_s) && (r_ptr >= w_point_s)) begin
                            // both past the point: keep both
                            w_c0_key   = w_key_p;
                            w_c0_press = 1'b1;
                            w_c1_press = 1'b1;
                        end else if (r_ktr >= r_ptr) begin
                            w_c1_key   = w_key_p;
                            w_c1_press = 1'b1;
                        end else begin
                            w_c0_key   = w_key_p;
                            w_c1_press = 1'b1;
                        end
                    end
                end
                default: begin
                    w_n = 2'd0;
                end
            endcase
        end
    end

    assign o_status.num_results = w_n;

    // payload capture, settings memory and command registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_op);
            r_key   <= i_key;
            r_kdown <= i_key_is_down;
            r_pdown <= i_partner_is_down;
            r_ktr   <= i_key_travel;
            r_ptr   <= i_partner_travel;
            r_np    <= i_new_partner;
            r_nm    <= i_new_mode;
            r_nf    <= i_new_full_enable;
            r_npt   <= i_new_point_tenths;
            r_rd    <= r_settings[KW'(i_key)];
        end
        if (i_cmd.exec && (r_op == OP_LOAD) && w_in_range) begin
            if (w_load_ok) begin
                r_settings[w_key_s] <= {PW'(r_np), r_nm, r_nf, w_new_point};
            end else begin
                r_settings[w_key_s] <= {w_key_p, MODE_LAST_WINS, 1'b0, DEFAULT_POINT};
            end
        end
        if (i_cmd.exec) begin
            r_out_key   <= 6'(w_c0_key);
            r_out_press <= w_c0_press;
            r_out_last  <= (w_n == 2'd1);
            r_c1_key    <= w_c1_key;
            r_c1_press  <= w_c1_press;
        end else if (i_cmd.emit2) begin
            r_out_key   <= 6'(r_c1_key);
            r_out_press <= r_c1_press;
            r_out_last  <= 1'b1;
        end
    end

    // enable and override flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= '0;
            r_override <= '0;
        end else if (i_cmd.exec) begin
            if (r_op == OP_LOAD) begin
                if (w_in_range) begin
                    r_enabled[w_key_s]  <= w_load_ok;
                    r_override[w_key_p] <= 1'b0;
                end
            end else begin
                // a released key is held against its physical state
                if (w_n != 2'd0) begin
                    r_override[w_c0_key] <= !w_c0_press;
                end
                if (w_n == 2'd2) begin
                    r_override[w_c1_key] <= !w_c1_press;
                end
            end
        end
    end

    assign o_target_key   = r_out_key;
    assign o_make_pressed = r_out_press;
    assign o_last         = r_out_last;

    a_distinct_targets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (w_n == 2'd2)) |-> (w_c0_key != w_c1_key))
        else $error("both commands of one transaction target the same key");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_LOAD)) |-> (w_n == 2'd0))
        else $error("settings load produced a command");

    a_emit2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit2 |-> $past(i_cmd.exec && (w_n == 2'd2)))
        else $error("second command without a two-command transaction");

endmodule

/* hdl/opposing_key_resolver.sv */
// opposing_key_resolver: one event in, up to two press or release commands out.
// first command strobed after the table read phase (ST_READ), second in the following cycle
// a new event is accepted whenever busy is low; busy is high for the single table read cycle
// the second command of an event overlaps the next accepted event; the receiver cannot stall
// reset (synchronous, active low) clears enable and override flags; the settings
// memory needs no clearing pass, a disabled key's entry is never consulted
module opposing_key_resolver import okr_pkg::*; #(
    parameter int KEY_COUNT            = 64,
    parameter int DEFAULT_POINT_TENTHS = 35
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_op,
    input  logic [5:0]                 i_key,
    input  logic                       i_key_is_down,
    input  logic                       i_partner_is_down,
    input  logic signed [TRAVEL_W-1:0] i_key_travel,
    input  logic signed [TRAVEL_W-1:0] i_partner_travel,
    input  logic [7:0]                 i_new_partner,
    input  logic [MODE_W-1:0]          i_new_mode,
    input  logic                       i_new_full_enable,
    input  logic [7:0]                 i_new_point_tenths,
    output logic                       o_strobe,
    output logic [5:0]                 o_target_key,
    output logic                       o_make_pressed,
    output logic                       o_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    okr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    okr_datapath #(
        .KEY_COUNT            (KEY_COUNT),
        .DEFAULT_POINT_TENTHS (DEFAULT_POINT_TENTHS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_op               (i_op),
        .i_key              (i_key),
        .i_key_is_down      (i_key_is_down),
        .i_partner_is_down  (i_partner_is_down),
        .i_key_travel       (i_key_travel),
        .i_partner_travel   (i_partner_travel),
        .i_new_partner      (i_new_partner),
        .i_new_mode         (i_new_mode),
        .i_new_full_enable  (i_new_full_enable),
        .i_new_point_tenths (i_new_point_tenths),
        .o_target_key       (o_target_key),
        .o_make_pressed     (o_make_pressed),
        .o_last             (o_last)
    );

endmodule
